>>> rtl/ilfs_pkg.sv
// ----------------------------------------------------------------------------
// ilfs_pkg
// Shared types and codes for the indexed list with free slots: word layouts,
// opcodes, status codes and the controller-to-datapath command set.
// ----------------------------------------------------------------------------
package ilfs_pkg;

  localparam int OPC_W    = 2;
  localparam int HND_W    = 32;
  localparam int SLOT_W   = 8;
  localparam int STRIDE_W = 9;
  localparam int STAT_W   = 2;

  // opcodes
  localparam logic [OPC_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPC_W-1:0] OP_TEST   = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [HND_W-1:0]    handle;
    logic [SLOT_W-1:0]   start_slot;
    logic [STRIDE_W-1:0] stride;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              list_empty;
  } out_word_t;

  // datapath micro-operations, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,     // capture input word, cursor <= start slot
    CMD_MISS,     // result <= not found
    CMD_FULL,     // result <= table full
    CMD_FREE_RD,  // read next link of the free list head
    CMD_POP,      // slot <= free head, free head <= its next link
    CMD_FRESH,    // slot <= first never-used slot
    CMD_LINK,     // store handle, link slot at tail
    CMD_TERM,     // terminate slot's next link, result <= ok
    CMD_PROBE,    // read handle at cursor
    CMD_STEP,     // cursor += stride, read handle there
    CMD_HIT,      // slot <= cursor, result <= ok, read its links
    CMD_UL_FIX,   // bypass the slot in the list
    CMD_UL_FREE,  // push the slot onto the free list
    CMD_EMIT      // load output register
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_search;
    logic is_remove;
    logic hnd_zero;
    logic free_avail;
    logic room;
    logic start_in;
    logic match;
    logic more;
    logic out_busy;
    logic ends_agree;
  } dp_stat_t;

endpackage

>>> rtl/ilfs_ctrl.sv
// ----------------------------------------------------------------------------
// ilfs_ctrl
// Sequencer for the indexed list: picks one datapath operation per cycle
// from the current state and the datapath status.
// ----------------------------------------------------------------------------
module ilfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ilfs_pkg::dp_stat_t stat,
  output ilfs_pkg::ctl_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CHK      = 9'b000000010,
    S_ADD_POP  = 9'b000000100,
    S_ADD_LINK = 9'b000001000,
    S_ADD_TERM = 9'b000010000,
    S_SR_CMP   = 9'b000100000,
    S_UL_FIX   = 9'b001000000,
    S_UL_FREE  = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = ilfs_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ilfs_pkg::CMD_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        priority if (stat.is_add) begin
          priority if (stat.hnd_zero) begin
            cmd.op    = ilfs_pkg::CMD_MISS;
            state_nxt = S_DONE;
          end else if (stat.free_avail) begin
            cmd.op    = ilfs_pkg::CMD_FREE_RD;
            state_nxt = S_ADD_POP;
          end else if (stat.room) begin
            cmd.op    = ilfs_pkg::CMD_FRESH;
            state_nxt = S_ADD_LINK;
          end else begin
            cmd.op    = ilfs_pkg::CMD_FULL;
            state_nxt = S_DONE;
          end
        end else if (stat.is_search && !stat.hnd_zero && stat.start_in) begin
          cmd.op    = ilfs_pkg::CMD_PROBE;
          state_nxt = S_SR_CMP;
        end else begin
          cmd.op    = ilfs_pkg::CMD_MISS;
          state_nxt = S_DONE;
        end
      end
      S_ADD_POP: begin
        cmd.op    = ilfs_pkg::CMD_POP;
        state_nxt = S_ADD_LINK;
      end
      S_ADD_LINK: begin
        cmd.op    = ilfs_pkg::CMD_LINK;
        state_nxt = S_ADD_TERM;
      end
      S_ADD_TERM: begin
        cmd.op    = ilfs_pkg::CMD_TERM;
        state_nxt = S_DONE;
      end
      // one probe per cycle; handle read issued the cycle before
      S_SR_CMP: begin
        priority if (stat.match) begin
          cmd.op    = ilfs_pkg::CMD_HIT;
          state_nxt = stat.is_remove ? S_UL_FIX : S_DONE;
        end else if (stat.more) begin
          cmd.op    = ilfs_pkg::CMD_STEP;
          state_nxt = S_SR_CMP;
        end else begin
          cmd.op    = ilfs_pkg::CMD_MISS;
          state_nxt = S_DONE;
        end
      end
      S_UL_FIX: begin
        cmd.op    = ilfs_pkg::CMD_UL_FIX;
        state_nxt = S_UL_FREE;
      end
      S_UL_FREE: begin
        cmd.op    = ilfs_pkg::CMD_UL_FREE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op    = ilfs_pkg::CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/ilfs_dpath.sv
// ----------------------------------------------------------------------------
// ilfs_dpath
// Slot table datapath: handle and link memories, list and free list
// pointers, search cursor and the output register.
// ----------------------------------------------------------------------------
module ilfs_dpath #(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ilfs_pkg::ctl_cmd_t  cmd,
  input  ilfs_pkg::in_word_t  in_word,
  output ilfs_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output ilfs_pkg::out_word_t out_word
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // slot index
  localparam int LW = $clog2(DEPTH) + 1;                 // link, holds null
  localparam int UW = $clog2(DEPTH + 1);                 // used count
  localparam int CW = $clog2(DEPTH + 512);               // cursor incl. overshoot
  localparam logic [LW-1:0] NULL_LINK = LW'(DEPTH);
  localparam logic [UW-1:0] USED_MAX  = UW'(DEPTH);

  // memories
  logic [ilfs_pkg::HND_W-1:0] handle_mem [DEPTH];
  logic [LW-1:0]              prev_mem   [DEPTH];
  logic [LW-1:0]              next_mem   [DEPTH];

  // control registers
  logic [LW-1:0] head_r, tail_r, free_r;
  logic [UW-1:0] used_r;
  logic          out_valid_r;

  // payload registers
  ilfs_pkg::in_word_t         item_r;
  logic [CW-1:0]              cur_r;
  logic [AW-1:0]              slot_r;
  logic [ilfs_pkg::STAT_W-1:0] res_r;
  ilfs_pkg::out_word_t        out_r;
  logic [ilfs_pkg::HND_W-1:0] hnd_rd_r;
  logic [LW-1:0]              prev_rd_r, next_rd_r;

  // memory port controls
  logic                       h_we, p_we, n_we;
  logic [AW-1:0]              h_wa, p_wa, n_wa;
  logic [ilfs_pkg::HND_W-1:0] h_wd;
  logic [LW-1:0]              p_wd, n_wd;
  logic                       h_re, p_re, n_re;
  logic [AW-1:0]              h_ra, p_ra, n_ra;

  logic [CW-1:0] cur_step;
  logic [CW-1:0] slot_ext;
  logic [LW-1:0] slot_link;
  logic          head_ok, tail_ok, free_ok;
  logic          rd_prev_ok, rd_next_ok;

  assign cur_step   = cur_r + CW'(item_r.stride);
  assign slot_ext   = CW'(slot_r);
  assign slot_link  = LW'(slot_r);
  assign head_ok    = (head_r < NULL_LINK);
  assign tail_ok    = (tail_r < NULL_LINK);
  assign free_ok    = (free_r < NULL_LINK);
  assign rd_prev_ok = (prev_rd_r < NULL_LINK);
  assign rd_next_ok = (next_rd_r < NULL_LINK);

  // status to controller
  always_comb begin
    stat.is_add     = (item_r.opcode == ilfs_pkg::OP_ADD);
    stat.is_search  = (item_r.opcode == ilfs_pkg::OP_REMOVE) ||
                      (item_r.opcode == ilfs_pkg::OP_TEST);
    stat.is_remove  = (item_r.opcode == ilfs_pkg::OP_REMOVE);
    stat.hnd_zero   = (item_r.handle == '0);
    stat.free_avail = free_ok;
    stat.room       = (used_r < USED_MAX);
    stat.start_in   = (cur_r < CW'(used_r));
    stat.match      = (hnd_rd_r == item_r.handle);
    stat.more       = (item_r.stride != '0) && (cur_step < CW'(used_r));
    stat.out_busy   = out_valid_r && out_stall;
    stat.ends_agree = (head_ok == tail_ok);
  end

  // memory port steering
  always_comb begin
    h_we = 1'b0; h_wa = slot_r; h_wd = item_r.handle;
    p_we = 1'b0; p_wa = slot_r; p_wd = tail_r;
    n_we = 1'b0; n_wa = slot_r; n_wd = NULL_LINK;
    h_re = 1'b0; h_ra = cur_r[AW-1:0];
    p_re = 1'b0; p_ra = cur_r[AW-1:0];
    n_re = 1'b0; n_ra = cur_r[AW-1:0];
    unique case (cmd.op)
      ilfs_pkg::CMD_FREE_RD: begin
        n_re = 1'b1;
        n_ra = free_r[AW-1:0];
      end
      ilfs_pkg::CMD_LINK: begin
        h_we = 1'b1;
        p_we = 1'b1;
        n_we = tail_ok;
        n_wa = tail_r[AW-1:0];
        n_wd = slot_link;
      end
      ilfs_pkg::CMD_TERM: begin
        n_we = 1'b1;
      end
      ilfs_pkg::CMD_PROBE: begin
        h_re = 1'b1;
      end
      ilfs_pkg::CMD_STEP: begin
        h_re = 1'b1;
        h_ra = cur_step[AW-1:0];
      end
      ilfs_pkg::CMD_HIT: begin
        p_re = 1'b1;
        n_re = 1'b1;
      end
      // neighbors bypass the slot; the slot's handle is cleared
      ilfs_pkg::CMD_UL_FIX: begin
        h_we = 1'b1;
        h_wd = '0;
        n_we = rd_prev_ok;
        n_wa = prev_rd_r[AW-1:0];
        n_wd = next_rd_r;
        p_we = rd_next_ok;
        p_wa = next_rd_r[AW-1:0];
        p_wd = prev_rd_r;
      end
      ilfs_pkg::CMD_UL_FREE: begin
        p_we = 1'b1;
        p_wd = NULL_LINK;
        n_we = 1'b1;
        n_wd = free_r;
      end
      default: begin
      end
    endcase
  end

  // handle memory
  always_ff @(posedge clk) begin
    if (h_we) begin
      handle_mem[h_wa] <= h_wd;
    end
    if (h_re) begin
      hnd_rd_r <= handle_mem[h_ra];
    end
  end

  // prev link memory
  always_ff @(posedge clk) begin
    if (p_we) begin
      prev_mem[p_wa] <= p_wd;
    end
    if (p_re) begin
      prev_rd_r <= prev_mem[p_ra];
    end
  end

  // next link memory
  always_ff @(posedge clk) begin
    if (n_we) begin
      next_mem[n_wa] <= n_wd;
    end
    if (n_re) begin
      next_rd_r <= next_mem[n_ra];
    end
  end

  // list pointers, used count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NULL_LINK;
      tail_r      <= NULL_LINK;
      free_r      <= NULL_LINK;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        ilfs_pkg::CMD_POP: begin
          free_r <= next_rd_r;
        end
        ilfs_pkg::CMD_FRESH: begin
          used_r <= used_r + UW'(1);
        end
        ilfs_pkg::CMD_LINK: begin
          if (!head_ok) begin
            head_r <= slot_link;
          end
          tail_r <= slot_link;
        end
        ilfs_pkg::CMD_UL_FIX: begin
          if (!rd_prev_ok) begin
            head_r <= next_rd_r;
          end
          if (!rd_next_ok) begin
            tail_r <= prev_rd_r;
          end
        end
        ilfs_pkg::CMD_UL_FREE: begin
          free_r <= slot_link;
        end
        default: begin
        end
      endcase
      if (cmd.op == ilfs_pkg::CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item, cursor, slot, result and output word
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ilfs_pkg::CMD_LOAD: begin
        item_r <= in_word;
        cur_r  <= CW'(in_word.start_slot);
      end
      ilfs_pkg::CMD_MISS:  res_r <= ilfs_pkg::ST_MISS;
      ilfs_pkg::CMD_FULL:  res_r <= ilfs_pkg::ST_FULL;
      ilfs_pkg::CMD_POP:   slot_r <= free_r[AW-1:0];
      ilfs_pkg::CMD_FRESH: slot_r <= used_r[AW-1:0];
      ilfs_pkg::CMD_TERM:  res_r <= ilfs_pkg::ST_OK;
      ilfs_pkg::CMD_STEP:  cur_r <= cur_step;
      ilfs_pkg::CMD_HIT: begin
        slot_r <= cur_r[AW-1:0];
        res_r  <= ilfs_pkg::ST_OK;
      end
      ilfs_pkg::CMD_EMIT: begin
        out_r.status     <= res_r;
        out_r.slot       <= (res_r == ilfs_pkg::ST_OK) ?
                            slot_ext[ilfs_pkg::SLOT_W-1:0] : '0;
        out_r.list_empty <= !head_ok;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

>>> rtl/indexed_list_with_free_slots.sv
// ----------------------------------------------------------------------------
// indexed_list_with_free_slots
// Slot table holding a doubly linked list of handles plus a free list.
// An add takes a freed slot (reading its free link first) or the first
//   never-used slot and links it at the tail; remove/test probe from the
//   start slot by the stride; a remove that hits unlinks and frees the slot.
//   One word at a time, taken once the result is registered; results wait while
//   the output stalls. The search probes one slot per cycle in the handle RAM.
// Reset: list, free list and used count empty; memories are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_with_free_slots #(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ilfs_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ilfs_pkg::out_word_t out_word
);

  ilfs_pkg::ctl_cmd_t cmd;
  ilfs_pkg::dp_stat_t stat;

  ilfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilfs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ilfs_pkg::CMD_EMIT) |-> (!out_valid || !out_stall))
    else $error("result emitted over a pending word");

  // after an accept the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after accept");

  // head and tail are null together
  a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
    stat.ends_agree)
    else $error("list head and tail disagree on emptiness");

endmodule
